// ----- hdl/spwc_pkg.sv -----
package spwc_pkg;

	// Field and state widths.
	localparam int PIN_W     = 15;
	localparam int CNT_W     = 16;
	localparam int CFG_W     = 16;
	localparam int LEN_W     = 17;
	localparam int ELAPSED_W = 17;

	// Debounce shape: attempts, each one reference read plus a run of matching reads.
	localparam int DB_ATTEMPTS = 3;
	localparam int DB_MATCHES  = 4;
	localparam int DB_READS    = DB_ATTEMPTS * (DB_MATCHES + 1);
	localparam int DB_VEC_W    = (DB_READS > PIN_W) ? DB_READS : PIN_W;
	localparam int DB_IDX_W    = (DB_VEC_W > 1) ? $clog2(DB_VEC_W) : 1;
	localparam int DB_POS_W    = $clog2(DB_VEC_W + 1);

	localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd100;
	localparam logic [CFG_W-1:0] PERIOD_RESET  = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_PIN  = 2'd1,
		MODE_MS   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_RECEIVED = 2'd1,
		EV_GONE     = 2'd2
	} event_t;

	typedef enum logic {
		REG_TIMEOUT = 1'b0,
		REG_PERIOD  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		event_t             event_code;
		logic [LEN_W-1:0]   pulse_length;
		logic               signal_present;
		logic               measuring;
	} result_t;

endpackage

// ----- hdl/spwc_debounce.sv -----
module spwc_debounce
	import spwc_pkg::*;
(
	input  logic [PIN_W-1:0] pin_reads,
	output logic             level
);

	logic [DB_VEC_W-1:0] reads_ext;

	assign reads_ext = DB_VEC_W'(pin_reads);

	// Each attempt starts where the previous one stopped; a mismatching read
	// is consumed by the failed attempt. Reads past the pin vector are low.
	always_comb begin
		logic [DB_POS_W-1:0] pos;
		logic                ref_bit;
		logic                fail;
		logic                done;
		pos     = '0;
		done    = 1'b0;
		level   = 1'b0;
		ref_bit = 1'b0;
		fail    = 1'b0;
		for (int a = 0; a < DB_ATTEMPTS; a++) begin
			if (!done) begin
				ref_bit = reads_ext[pos[DB_IDX_W-1:0]];
				pos     = pos + 1'b1;
				fail    = 1'b0;
				for (int m = 0; m < DB_MATCHES; m++) begin
					if (!fail) begin
						if (reads_ext[pos[DB_IDX_W-1:0]] != ref_bit) begin
							fail = 1'b1;
						end
						pos = pos + 1'b1;
					end
				end
				if (!fail) begin
					done  = 1'b1;
					level = ref_bit;
				end
			end
		end
	end

endmodule

// ----- hdl/spwc_core.sv -----
module spwc_core
	import spwc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [1:0]       mode,
	input  logic             level,
	input  logic [CFG_W-1:0] timeout_limit,
	input  logic [CFG_W-1:0] counter_period,
	output result_t          res
);

	logic [CNT_W-1:0]     tick_count_q, tick_count_d;
	logic                 running_q, running_d;
	logic                 reading_q, reading_d;
	logic                 avail_q, avail_d;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
	logic [LEN_W-1:0]     latched_q, latched_d;
	event_t               event_d;

	always_comb begin
		tick_count_d = tick_count_q;
		running_d    = running_q;
		reading_d    = reading_q;
		avail_d      = avail_q;
		elapsed_d    = elapsed_q;
		latched_d    = latched_q;
		event_d      = EV_NONE;
		case (mode_t'(mode))
			MODE_TICK: begin
				if (running_q) begin
					// Reaching the period wraps the counter and aborts the measurement.
					if (tick_count_q >= counter_period) begin
						tick_count_d = '0;
						reading_d    = 1'b0;
					end else begin
						tick_count_d = tick_count_q + 1'b1;
					end
				end
			end
			MODE_PIN: begin
				if (level) begin
					tick_count_d = '0;
					running_d    = 1'b1;
					elapsed_d    = '0;
					reading_d    = 1'b1;
				end else if (reading_q) begin
					latched_d = LEN_W'(tick_count_q) + 1'b1;
					running_d = 1'b0;
					reading_d = 1'b0;
					avail_d   = 1'b1;
					event_d   = EV_RECEIVED;
				end
			end
			MODE_MS: begin
				if (reading_q || avail_q) begin
					if (elapsed_q >= ELAPSED_W'(timeout_limit)) begin
						avail_d = 1'b0;
						event_d = EV_GONE;
					end else begin
						elapsed_d = elapsed_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			running_q    <= 1'b0;
			reading_q    <= 1'b0;
			avail_q      <= 1'b0;
			elapsed_q    <= '0;
			latched_q    <= '0;
		end else if (step) begin
			tick_count_q <= tick_count_d;
			running_q    <= running_d;
			reading_q    <= reading_d;
			avail_q      <= avail_d;
			elapsed_q    <= elapsed_d;
			latched_q    <= latched_d;
		end
	end

	assign res.event_code     = event_d;
	assign res.pulse_length   = latched_d;
	assign res.signal_present = avail_d;
	assign res.measuring      = reading_d;

endmodule

// ----- hdl/spwc_outq.sv -----
module spwc_outq
	import spwc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	result_t head_q;
	result_t skid_q;
	logic    head_valid_q;
	logic    skid_valid_q;
	logic    pop;

	assign pop       = head_valid_q && out_ready;
	assign out_valid = head_valid_q;
	assign head      = head_q;
	assign full      = skid_valid_q;

	// Two entries: a new result is taken while the head still waits.
	// The producer only pushes when the skid entry is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= skid_valid_q ? skid_q : push_data;
		end else if (push && !head_valid_q) begin
			head_q <= push_data;
		end
		if (push && head_valid_q && !pop) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- hdl/servo_pulse_width_capture.sv -----
// Servo pulse width capture.
// Input channel (in_valid/in_ready) takes one item per transfer: a timer tick,
// a pin change event with fifteen raw pin reads, or a millisecond tick.
// Every accepted item yields exactly one result on the output channel
// (out_valid/out_ready): an event code, the last latched pulse length in
// ticks, and the present and measuring flags after that item.
// An input transfer loads the input register; debounce and the state update
// work on it combinationally, and the result is written into the result queue
// once the queue's skid entry is free; a queued result drives out_valid.
// Throughput is one item per cycle while the result queue is not full.
// The result queue holds two entries, so a stalled receiver does not stop the
// next item; in_ready drops only once both entries and the input register are
// occupied, and resumes as soon as the receiver takes a result.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 is the timeout in milliseconds, index 1 the counter period.
// Reset clears all measurement state and queues and loads a timeout of 100
// and a period of 65535.
module servo_pulse_width_capture
	import spwc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [PIN_W-1:0] pin_reads,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       event_code,
	output logic [LEN_W-1:0] pulse_length,
	output logic             signal_present,
	output logic             measuring,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] timeout_q;
	logic [CFG_W-1:0] period_q;
	logic             valid_s1;
	logic [1:0]       mode_s1;
	logic [PIN_W-1:0] reads_s1;
	logic             level;
	logic             advance;
	logic             q_full;
	result_t          res;
	result_t          head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			period_q  <= PERIOD_RESET;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_PERIOD:  period_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			reads_s1 <= pin_reads;
		end
	end

	spwc_debounce u_debounce (
		.pin_reads (reads_s1),
		.level     (level)
	);

	spwc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.mode           (mode_s1),
		.level          (level),
		.timeout_limit  (timeout_q),
		.counter_period (period_q),
		.res            (res)
	);

	spwc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign event_code     = head.event_code;
	assign pulse_length   = head.pulse_length;
	assign signal_present = head.signal_present;
	assign measuring      = head.measuring;

`ifndef SYNTHESIS
	a_gone_clears_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_GONE |-> !signal_present)
		else $error("signal gone reported while still present");

	a_received_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_RECEIVED |-> signal_present && !measuring)
		else $error("pulse received with inconsistent flags");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid)
		else $error("input stalled with no work held");

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after state update");
`endif

endmodule
